// ===== sv/pga_pkg.sv =====
`default_nettype none
package pga_pkg;

  localparam int POS_W_DEF = 32;
  localparam int VEL_W_DEF = 24;
  localparam int GAIN_W    = 12;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 12'd768;
  localparam int ACC_W     = 32;
  // one guard bit above the output width tells a clamp apart
  localparam int QUO_W     = ACC_W + 1;
  localparam int DEN_SHIFT = 8;
  localparam int MUL_DIGIT = 32;
  localparam int STAT_W    = 2;

  typedef enum logic [STAT_W-1:0] {
    ST_OK          = 2'd0,
    ST_ZERO_RANGE  = 2'd1,
    ST_NOT_CLOSING = 2'd2,
    ST_SATURATED   = 2'd3
  } status_e;

  typedef struct packed {
    logic zero;
    logic nclose;
  } geo_flags_t;

  function automatic int imax(int a, int b);
    return (a > b) ? a : b;
  endfunction

  // registers through pga_mul: input stage, one stage per digit product, sign stage
  function automatic int mul_lat(int wa, int wb);
    return ((wa + MUL_DIGIT - 1) / MUL_DIGIT) * ((wb + MUL_DIGIT - 1) / MUL_DIGIT) + 2;
  endfunction

endpackage
`default_nettype wire

// ===== sv/pga_ifs.sv =====
`default_nettype none
interface pga_in_if import pga_pkg::*; #(
  parameter int PW = POS_W_DEF,
  parameter int VW = VEL_W_DEF
);
  logic valid;
  logic ready;
  logic signed [PW-1:0] interceptor_x;
  logic signed [PW-1:0] interceptor_y;
  logic signed [PW-1:0] interceptor_z;
  logic signed [PW-1:0] target_x;
  logic signed [PW-1:0] target_y;
  logic signed [PW-1:0] target_z;
  logic signed [VW-1:0] interceptor_vx;
  logic signed [VW-1:0] interceptor_vy;
  logic signed [VW-1:0] interceptor_vz;
  logic signed [VW-1:0] target_vx;
  logic signed [VW-1:0] target_vy;
  logic signed [VW-1:0] target_vz;

  modport source (
    output valid, interceptor_x, interceptor_y, interceptor_z,
           target_x, target_y, target_z, interceptor_vx, interceptor_vy,
           interceptor_vz, target_vx, target_vy, target_vz,
    input  ready
  );
  modport sink (
    input  valid, interceptor_x, interceptor_y, interceptor_z,
           target_x, target_y, target_z, interceptor_vx, interceptor_vy,
           interceptor_vz, target_vx, target_vy, target_vz,
    output ready
  );
endinterface

interface pga_out_if import pga_pkg::*;;
  logic valid;
  logic ready;
  logic signed [ACC_W-1:0] accel_x;
  logic signed [ACC_W-1:0] accel_y;
  logic [STAT_W-1:0] status;

  modport source (output valid, accel_x, accel_y, status, input ready);
  modport sink (input valid, accel_x, accel_y, status, output ready);
endinterface

interface pga_cfg_if import pga_pkg::*;;
  logic valid;
  logic ready;
  logic [GAIN_W-1:0] nav_gain;

  modport source (output valid, nav_gain, input ready);
  modport sink (input valid, nav_gain, output ready);
endinterface
`default_nettype wire

// ===== sv/pga_delay.sv =====
`default_nettype none
module pga_delay import pga_pkg::*; #(
  parameter int W = 8,
  parameter int N = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  if (N == 0) begin : g_none
    assign q_o = d_i;
  end else begin : g_line
    logic [W-1:0] tap_q [N];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tap_q[0] <= d_i;
        for (int k = 1; k < N; k++) tap_q[k] <= tap_q[k-1];
      end
    end
    assign q_o = tap_q[N-1];
  end

endmodule
`default_nettype wire

// ===== sv/pga_mul.sv =====
`default_nettype none
module pga_mul import pga_pkg::*; #(
  parameter int WA = 8,
  parameter int WB = 8,
  parameter bit SGN = 1'b0
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [WA-1:0]   a_i,
  input  logic [WB-1:0]   b_i,
  output logic [WA+WB-1:0] p_o
);

  localparam int NA = (WA + MUL_DIGIT - 1) / MUL_DIGIT;
  localparam int NB = (WB + MUL_DIGIT - 1) / MUL_DIGIT;
  localparam int NP = NA * NB;
  localparam int AW = NA * MUL_DIGIT;
  localparam int BW = NB * MUL_DIGIT;
  localparam int SW = AW + BW;

  logic [AW-1:0] am_q  [NP];
  logic [BW-1:0] bm_q  [NP];
  logic          neg_q [NP+1];
  logic [SW-1:0] acc_q [NP+1];
  logic [WA+WB-1:0] p_q;
  logic [WA-1:0] amag;
  logic [WB-1:0] bmag;
  logic          neg;

  always_comb begin
    amag = a_i;
    bmag = b_i;
    neg  = 1'b0;
    if (SGN) begin
      amag = a_i[WA-1] ? (WA'(0) - a_i) : a_i;
      bmag = b_i[WB-1] ? (WB'(0) - b_i) : b_i;
      neg  = a_i[WA-1] ^ b_i[WB-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      am_q[0]  <= AW'(amag);
      bm_q[0]  <= BW'(bmag);
      neg_q[0] <= neg;
      acc_q[0] <= '0;
    end
  end

  // one digit-by-digit partial product per stage
  for (genvar k = 1; k <= NP; k++) begin : g_pp
    localparam int I = (k - 1) / NB;
    localparam int J = (k - 1) % NB;
    logic [2*MUL_DIGIT-1:0] pp;
    assign pp = am_q[k-1][I*MUL_DIGIT +: MUL_DIGIT] * bm_q[k-1][J*MUL_DIGIT +: MUL_DIGIT];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_q[k] <= acc_q[k-1] + (SW'(pp) << ((I + J) * MUL_DIGIT));
        neg_q[k] <= neg_q[k-1];
      end
    end
    if (k < NP) begin : g_fwd
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          am_q[k] <= am_q[k-1];
          bm_q[k] <= bm_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= neg_q[NP] ? (WA+WB)'(SW'(0) - acc_q[NP]) : (WA+WB)'(acc_q[NP]);
    end
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

// ===== sv/pga_sqrt.sv =====
`default_nettype none
module pga_sqrt import pga_pkg::*; #(
  parameter int NW = 16
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [NW-1:0]   n_i,
  output logic [NW/2-1:0] root_o
);

  localparam int H = NW / 2;

  logic [NW-1:0] n_q    [H];
  logic [H-1:0]  rem_q  [H];
  logic [H-1:0]  root_q [H+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q[0]    <= n_i;
      rem_q[0]  <= '0;
      root_q[0] <= '0;
    end
  end

  // one root bit per stage, two radicand bits brought down each time
  for (genvar k = 1; k <= H; k++) begin : g_step
    logic [H+1:0] rt;
    logic [H+1:0] tr;
    logic         ge;
    assign rt = {rem_q[k-1], n_q[k-1][NW-1 -: 2]};
    assign tr = {root_q[k-1], 2'b01};
    assign ge = (rt >= tr);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[k] <= {root_q[k-1][H-2:0], ge};
      end
    end
    if (k < H) begin : g_fwd
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= ge ? H'(rt - tr) : H'(rt);
          n_q[k]   <= n_q[k-1] << 2;
        end
      end
    end
  end

  assign root_o = root_q[H];

endmodule
`default_nettype wire

// ===== sv/pga_div.sv =====
`default_nettype none
module pga_div import pga_pkg::*; #(
  parameter int NUMW = 64,
  parameter int DENW = 32,
  parameter int QW   = 33
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [NUMW-1:0] num_i,
  input  logic [DENW-1:0] den_i,
  output logic [QW-1:0]   quo_o,
  output logic            ovf_o
);

  localparam int HW   = NUMW - QW;
  localparam int CMPW = imax(HW, DENW);

  logic [DENW-1:0] rem_q [QW];
  logic [DENW-1:0] den_q [QW];
  logic [QW-1:0]   nl_q  [QW];
  logic [QW-1:0]   quo_q [QW+1];
  logic            ovf_q [QW+1];
  logic [HW-1:0]   hi;

  assign hi = num_i[NUMW-1:QW];

  // quotient too wide for QW bits when the top part already reaches den
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ovf_q[0] <= (CMPW'(hi) >= CMPW'(den_i));
      rem_q[0] <= DENW'(hi);
      den_q[0] <= den_i;
      nl_q[0]  <= num_i[QW-1:0];
      quo_q[0] <= '0;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_step
    logic [DENW:0] rt;
    logic          ge;
    assign rt = {rem_q[k-1], nl_q[k-1][QW-k]};
    assign ge = (rt >= {1'b0, den_q[k-1]});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[k] <= {quo_q[k-1][QW-2:0], ge};
        ovf_q[k] <= ovf_q[k-1];
      end
    end
    if (k < QW) begin : g_fwd
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= ge ? DENW'(rt - {1'b0, den_q[k-1]}) : DENW'(rt);
          den_q[k] <= den_q[k-1];
          nl_q[k]  <= nl_q[k-1];
        end
      end
    end
  end

  assign quo_o = quo_q[QW];
  assign ovf_o = ovf_q[QW];

endmodule
`default_nettype wire

// ===== sv/pn_guidance_accel.sv =====
// planar proportional-navigation acceleration command
// item_i: one transfer carries interceptor and target position and velocity
// res_o: one transfer per item with accel_x, accel_y (Q24.8) and status
//   status: ok, zero range, not closing, or saturated (either axis clamped)
// cfg_i: writes nav_gain (Q4.8); always ready, write it only while no item is in flight
// pipeline depth: set by the chain of digit-serial multipliers, the one-bit-per-stage
//   square root of |r x v|^2 and the 33-stage restoring divider; in general it follows
//   the localparams below
// throughput: one item per cycle except while stalled; results leave in input order
// stall: a low res_o.ready with a result waiting freezes the whole pipeline and
//   item_i.ready drops in the same cycle, so nothing is lost or repeated
// reset: empties the pipeline and sets nav_gain to 3.0
`default_nettype none
module pn_guidance_accel import pga_pkg::*; #(
  parameter int POS_WIDTH = POS_W_DEF,
  parameter int VEL_WIDTH = VEL_W_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pga_cfg_if.sink   cfg_i,
  pga_in_if.sink    item_i,
  pga_out_if.source res_o
);

  localparam int RW   = POS_WIDTH + 1;
  localparam int VRW  = VEL_WIDTH + 1;
  localparam int MW   = imax(RW, VRW);
  localparam int E    = 2 * MW + 2;
  localparam int B1W  = GAIN_W + E;
  localparam int BW   = GAIN_W + 2 * E;
  localparam int NUMW = BW + RW;
  localparam int DENW = 2 * E + DEN_SHIFT;

  localparam int L1 = mul_lat(MW, MW);
  localparam int LG = mul_lat(GAIN_W, E);
  localparam int L2 = mul_lat(E, E);
  localparam int L4 = mul_lat(B1W, E);
  localparam int L5 = mul_lat(BW, RW);
  localparam int LD = QUO_W + 1;

  localparam int T_A  = 1;
  localparam int T_S  = T_A + L1 + 1;
  localparam int T_RT = T_S + L2 + 1 + E + 1;
  localparam int T_B  = T_RT + L4;
  localparam int T_N  = T_B + L5;
  localparam int T_Q  = T_N + LD;

  localparam logic [QUO_W-1:0] LIM_NEG = QUO_W'(1) << (ACC_W - 1);
  localparam logic [QUO_W-1:0] LIM_POS = LIM_NEG - QUO_W'(1);

  logic en;
  logic out_valid_q;
  logic [GAIN_W-1:0] gain_q;
  logic [T_Q-1:0] vld_q;

  // configuration
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RESET;
    end else if (cfg_i.valid) begin
      gain_q <= cfg_i.nav_gain;
    end
  end

  assign en           = !out_valid_q || res_o.ready;
  assign item_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[T_Q-2:0], item_i.valid};
    end
  end

  // relative position and velocity
  logic signed [POS_WIDTH-1:0] ip [3];
  logic signed [POS_WIDTH-1:0] tp [3];
  logic signed [VEL_WIDTH-1:0] iv [3];
  logic signed [VEL_WIDTH-1:0] tv [3];
  logic signed [MW-1:0] r_q [3];
  logic signed [MW-1:0] v_q [3];

  always_comb begin
    ip[0] = item_i.interceptor_x;
    ip[1] = item_i.interceptor_y;
    ip[2] = item_i.interceptor_z;
    tp[0] = item_i.target_x;
    tp[1] = item_i.target_y;
    tp[2] = item_i.target_z;
    iv[0] = item_i.interceptor_vx;
    iv[1] = item_i.interceptor_vy;
    iv[2] = item_i.interceptor_vz;
    tv[0] = item_i.target_vx;
    tv[1] = item_i.target_vy;
    tv[2] = item_i.target_vz;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        r_q[i] <= MW'(RW'(tp[i]) - RW'(ip[i]));
        v_q[i] <= MW'(VRW'(tv[i]) - VRW'(iv[i]));
      end
    end
  end

  // squares of r, terms of r.v and of r x v
  logic [MW-1:0] op_a [12];
  logic [MW-1:0] op_b [12];
  logic signed [2*MW-1:0] pr [12];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      op_a[i]   = r_q[i];
      op_b[i]   = r_q[i];
      op_a[3+i] = r_q[i];
      op_b[3+i] = v_q[i];
    end
    op_a[6]  = r_q[1]; op_b[6]  = v_q[2];
    op_a[7]  = r_q[2]; op_b[7]  = v_q[1];
    op_a[8]  = r_q[2]; op_b[8]  = v_q[0];
    op_a[9]  = r_q[0]; op_b[9]  = v_q[2];
    op_a[10] = r_q[0]; op_b[10] = v_q[1];
    op_a[11] = r_q[1]; op_b[11] = v_q[0];
  end

  for (genvar m = 0; m < 12; m++) begin : g_prod
    pga_mul #(.WA(MW), .WB(MW), .SGN(1'b1)) u_mul (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (op_a[m]),
      .b_i   (op_b[m]),
      .p_o   (pr[m])
    );
  end

  logic [E-1:0]        r2_q;
  logic signed [E-1:0] dot_q;
  logic signed [E-1:0] cr_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      r2_q     <= E'(pr[0]) + E'(pr[1]) + E'(pr[2]);
      dot_q    <= E'(pr[3]) + E'(pr[4]) + E'(pr[5]);
      cr_q[0]  <= E'(pr[6]) - E'(pr[7]);
      cr_q[1]  <= E'(pr[8]) - E'(pr[9]);
      cr_q[2]  <= E'(pr[10]) - E'(pr[11]);
    end
  end

  geo_flags_t flags_s;
  geo_flags_t flags_q;
  logic [E-1:0] dot_mag;

  assign flags_s.zero   = (r2_q == '0);
  assign flags_s.nclose = !dot_q[E-1];
  assign dot_mag        = dot_q[E-1] ? (E'(0) - dot_q) : dot_q;

  // |r x v|^2 and its square root
  logic signed [2*E-1:0] csq [3];
  logic [2*E-1:0] c2_q;
  logic [E-1:0]   root;

  for (genvar m = 0; m < 3; m++) begin : g_csq
    pga_mul #(.WA(E), .WB(E), .SGN(1'b1)) u_mul (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (cr_q[m]),
      .b_i   (cr_q[m]),
      .p_o   (csq[m])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c2_q <= csq[0] + csq[1] + csq[2];
    end
  end

  pga_sqrt #(.NW(2 * E)) u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .n_i    (c2_q),
    .root_o (root)
  );

  // gain times closing term, then times the rate numerator
  logic [B1W-1:0] base1;
  logic [B1W-1:0] base1_d;
  logic [BW-1:0]  base;

  pga_mul #(.WA(GAIN_W), .WB(E), .SGN(1'b0)) u_gain (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (gain_q),
    .b_i   (dot_mag),
    .p_o   (base1)
  );

  pga_delay #(.W(B1W), .N(T_RT - T_S - LG)) u_dly_base1 (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (base1),
    .q_o   (base1_d)
  );

  pga_mul #(.WA(B1W), .WB(E), .SGN(1'b0)) u_base (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (base1_d),
    .b_i   (root),
    .p_o   (base)
  );

  // (r.r)^2 for the denominator
  logic [2*E-1:0] rr2;
  logic [2*E-1:0] rr2_d;

  pga_mul #(.WA(E), .WB(E), .SGN(1'b0)) u_den (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (r2_q),
    .b_i   (r2_q),
    .p_o   (rr2)
  );

  pga_delay #(.W(2 * E), .N(T_N - T_S - L2)) u_dly_den (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (rr2),
    .q_o   (rr2_d)
  );

  // line-of-sight normal components
  logic signed [MW-1:0] r0_d;
  logic signed [MW-1:0] r1_d;
  logic [RW-1:0] r0_mag;
  logic [RW-1:0] r1_mag;
  logic [1:0] neg_b;
  logic [1:0] neg_q;

  pga_delay #(.W(2 * MW), .N(T_B - T_A)) u_dly_r (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   ({r_q[1], r_q[0]}),
    .q_o   ({r1_d, r0_d})
  );

  assign r0_mag   = RW'(r0_d[MW-1] ? (MW'(0) - r0_d) : r0_d);
  assign r1_mag   = RW'(r1_d[MW-1] ? (MW'(0) - r1_d) : r1_d);
  // x is negative when r_y is positive, y when r_x is negative
  assign neg_b[0] = !r1_d[MW-1] && (r1_d != '0);
  assign neg_b[1] = r0_d[MW-1];

  pga_delay #(.W(2), .N(T_Q - T_B)) u_dly_neg (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (neg_b),
    .q_o   (neg_q)
  );

  pga_delay #(.W($bits(geo_flags_t)), .N(T_Q - T_S)) u_dly_flags (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (flags_s),
    .q_o   (flags_q)
  );

  logic [NUMW-1:0]  num_x;
  logic [NUMW-1:0]  num_y;
  logic [DENW-1:0]  den;
  logic [QUO_W-1:0] qx;
  logic [QUO_W-1:0] qy;
  logic ovf_x;
  logic ovf_y;

  assign den = {rr2_d, DEN_SHIFT'(0)};

  pga_mul #(.WA(BW), .WB(RW), .SGN(1'b0)) u_num_x (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (base),
    .b_i   (r1_mag),
    .p_o   (num_x)
  );

  pga_mul #(.WA(BW), .WB(RW), .SGN(1'b0)) u_num_y (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (base),
    .b_i   (r0_mag),
    .p_o   (num_y)
  );

  pga_div #(.NUMW(NUMW), .DENW(DENW), .QW(QUO_W)) u_div_x (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (num_x),
    .den_i (den),
    .quo_o (qx),
    .ovf_o (ovf_x)
  );

  pga_div #(.NUMW(NUMW), .DENW(DENW), .QW(QUO_W)) u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (num_y),
    .den_i (den),
    .quo_o (qy),
    .ovf_o (ovf_y)
  );

  // sign, clamp and status
  logic sat_x;
  logic sat_y;
  logic [ACC_W-1:0] ax;
  logic [ACC_W-1:0] ay;
  logic [ACC_W-1:0] ax_d;
  logic [ACC_W-1:0] ay_d;
  status_e st_d;
  logic [ACC_W-1:0] ax_q;
  logic [ACC_W-1:0] ay_q;
  status_e st_q;

  assign sat_x = ovf_x || (qx > (neg_q[0] ? LIM_NEG : LIM_POS));
  assign sat_y = ovf_y || (qy > (neg_q[1] ? LIM_NEG : LIM_POS));

  always_comb begin
    if (sat_x) ax = ACC_W'(neg_q[0] ? LIM_NEG : LIM_POS);
    else       ax = neg_q[0] ? ACC_W'(QUO_W'(0) - qx) : ACC_W'(qx);
    if (sat_y) ay = ACC_W'(neg_q[1] ? LIM_NEG : LIM_POS);
    else       ay = neg_q[1] ? ACC_W'(QUO_W'(0) - qy) : ACC_W'(qy);
    priority if (flags_q.zero) begin
      ax_d = '0;
      ay_d = '0;
      st_d = ST_ZERO_RANGE;
    end else if (flags_q.nclose) begin
      ax_d = '0;
      ay_d = '0;
      st_d = ST_NOT_CLOSING;
    end else begin
      ax_d = ax;
      ay_d = ay;
      st_d = (sat_x || sat_y) ? ST_SATURATED : ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vld_q[T_Q-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax_q <= ax_d;
      ay_q <= ay_d;
      st_q <= st_d;
    end
  end

  assign res_o.valid   = out_valid_q;
  assign res_o.accel_x = ax_q;
  assign res_o.accel_y = ay_q;
  assign res_o.status  = st_q;

endmodule
`default_nettype wire
